// File: hw/rtl/ris_pkg.sv
// Shared types, constants and helper functions for the Richardson iteration solver.
`default_nettype none
package ris_pkg;

  localparam int VW       = 32;
  localparam int FRAC     = 24;
  localparam int IDX_W    = 6;
  localparam int ORD_W    = 7;
  localparam int MAX_ORDER = 64;
  localparam int CNT_W    = 20;
  localparam int TOL_W    = 25;
  localparam int ACC_W    = 48;
  localparam int NORM_W   = 46;

  localparam logic [1:0] REQ_WR_COEFF = 2'd0;
  localparam logic [1:0] REQ_WR_RHS   = 2'd1;
  localparam logic [1:0] REQ_SOLVE    = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  localparam logic [1:0] CFG_STEP  = 2'd0;
  localparam logic [1:0] CFG_TOL   = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;
  localparam logic [1:0] CFG_ORDER = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic signed [VW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                 is_status;
    logic signed [VW-1:0] solution_value;
    logic [CNT_W-1:0]     iterations_done;
    logic                 converged;
  } out_word_t;

  typedef struct packed {
    logic issue;
    logic zero_x;
    logic clear;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_NRM, ST_NDRAIN, ST_TH1, ST_TH2, ST_MAC, ST_DRAIN,
    ST_FIN1, ST_FIN2, ST_FIN3, ST_SWEND, ST_DONE
  } state_t;

  // Saturate a wide signed value to the signed value range.
  function automatic logic signed [VW-1:0] sat_v(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = (ACC_W+1)'(signed'({1'b0, {(VW-1){1'b1}}}));
    lo = -hi - (ACC_W+1)'(1);
    if (v > hi) return {1'b0, {(VW-1){1'b1}}};
    else if (v < lo) return {1'b1, {(VW-1){1'b0}}};
    else return v[VW-1:0];
  endfunction

  // Magnitude of a signed value as an unsigned word.
  function automatic logic [VW-1:0] mag_v(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ris_mac.sv
// Two-stage multiply-accumulate unit for one matrix row times the solution vector.
`default_nettype none
module ris_mac import ris_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mac_ctl_t                ctl,
  input  wire logic signed [VW-1:0]    coeff,
  input  wire logic signed [VW-1:0]    xval,
  output logic signed [ACC_W-1:0]      acc,
  output logic                         busy
);

  logic              v1;
  logic              v2;
  logic [2*VW-1:0]   prod;
  logic              neg;
  logic signed [VW-1:0] xs;
  logic [2*VW-FRAC-1:0] prod_sh;

  assign xs = ctl.zero_x ? '0 : xval;
  assign prod_sh = prod[2*VW-1:FRAC];
  assign busy = v1 | v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= mag_v(coeff) * mag_v(xs);
      neg  <= coeff[VW-1] ^ xs[VW-1];
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (v2) begin
      if (neg) acc <= acc - ACC_W'(prod_sh);
      else acc <= acc + ACC_W'(prod_sh);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/richardson_iteration_solver.sv
// Top level of the Richardson iteration solver with its memories and sequencer.
//
// Usage: words on the input channel either load the system (matrix entries and
// right-hand-side entries, no result word), start a solve, or read one entry of
// the solution. A solve and a read each give exactly one word on the output
// channel. Both channels use valid and stall; a word moves when valid is high
// and stall is low. The user must write the configuration registers through the
// plain write port only while the block is idle; the block does not enforce it.
//
// Throughput: loads are taken one per cycle while the block is idle. A read's
// result word passes from the read state into the output register, and the next
// word is taken once the block is idle again. A solve first forms the right-hand
// side norm and threshold and then runs sweeps, each bounded by the single
// coefficient memory read port that feeds one product per cycle within a row.
// While a solve or read is in flight the input is stalled.
//
// Reset clears the sequencer and marks the solution as all zero. Matrix and
// right-hand-side memories are not cleared. When the receiver stalls, the
// finished result waits in the output register; a later read or solve then
// holds in its last state, with the input stalled, until that register is free.
`default_nettype none
module richardson_iteration_solver import ris_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_word_t        in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_word_t            out_data,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [VW-1:0]   cfg_data
);

  // Configuration registers.
  logic signed [VW-1:0] step_size;
  logic [TOL_W-1:0]     tolerance;
  logic [CNT_W-1:0]     iter_limit;
  logic [ORD_W-1:0]     order_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= -VW'(503316);
      tolerance      <= TOL_W'(16777);
      iter_limit     <= CNT_W'(100000);
      order_in_use   <= ORD_W'(MAX_ORDER);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP:  step_size      <= cfg_data;
        CFG_TOL:   tolerance      <= cfg_data[TOL_W-1:0];
        CFG_LIMIT: iter_limit     <= cfg_data[CNT_W-1:0];
        CFG_ORDER: order_in_use   <= cfg_data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic [IDX_W-1:0] i_idx, j_idx, n_last, rd_row, solved_last;
  logic             bank, xz, xv, th_pass, conv;
  logic [NORM_W-1:0] norm, rnorm, t_reg, thr;
  logic [46:0]      p_hi;
  logic [48:0]      p_lo;
  logic [CNT_W-1:0] sweep_count, limit;
  logic signed [VW-1:0] r_q, xi;
  logic [2*VW-1:0]  sq, sp, nsq;
  logic             spneg, nv1, nv2;

  logic in_acc;
  assign in_acc   = in_valid && (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);

  // The coefficient memory holds the whole matrix, row-major.
  logic signed [VW-1:0] coeff_mem [MAX_ORDER*MAX_ORDER];
  logic signed [VW-1:0] coeff_q;
  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == REQ_WR_COEFF)
      coeff_mem[{in_data.row, in_data.col}] <= in_data.value;
    coeff_q <= coeff_mem[{i_idx, j_idx}];
  end

  logic signed [VW-1:0] rhs_mem [MAX_ORDER];
  logic signed [VW-1:0] rhs_q;
  logic [IDX_W-1:0]     rhs_raddr;
  assign rhs_raddr = (state == ST_NRM) ? j_idx : i_idx;
  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == REQ_WR_RHS)
      rhs_mem[in_data.row] <= in_data.value;
    rhs_q <= rhs_mem[rhs_raddr];
  end

  // Two solution banks: one holds the previous sweep, the other the new one.
  logic signed [VW-1:0] xa_mem [MAX_ORDER];
  logic signed [VW-1:0] xb_mem [MAX_ORDER];
  logic signed [VW-1:0] xa_q, xb_q, x_q, x_new;
  logic [IDX_W-1:0]     x_raddr;
  logic                 x_we;

  always_comb begin
    case (state)
      ST_IDLE: x_raddr = in_data.row;
      ST_RD:   x_raddr = rd_row;
      ST_MAC:  x_raddr = j_idx;
      default: x_raddr = i_idx;
    endcase
  end

  assign x_we = (state == ST_FIN3);
  assign x_q  = bank ? xb_q : xa_q;

  always_ff @(posedge clk) begin
    if (x_we && !bank) xb_mem[i_idx] <= x_new;
    if (x_we && bank)  xa_mem[i_idx] <= x_new;
    xa_q <= xa_mem[x_raddr];
    xb_q <= xb_mem[x_raddr];
  end

  // Row product unit.
  mac_ctl_t mac_ctl;
  logic signed [ACC_W-1:0] acc;
  logic mac_busy;

  assign mac_ctl.issue  = (state == ST_MAC);
  assign mac_ctl.zero_x = xz;
  assign mac_ctl.clear  = (state == ST_FIN3) || (state == ST_TH2) || (state == ST_SWEND);

  ris_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .coeff (coeff_q),
    .xval  (x_q),
    .acc   (acc),
    .busy  (mac_busy)
  );

  // Datapath helpers.
  logic [NORM_W-1:0] th_sum;
  logic signed [ACC_W:0] diff;
  logic signed [ACC_W:0] upd;
  logic [2*VW-FRAC-1:0]  sp_sh;
  logic                  last_sweep, out_free;

  assign th_sum = p_hi[NORM_W-1:0] + NORM_W'(p_lo[48:FRAC]);
  assign diff   = (ACC_W+1)'(acc) - (ACC_W+1)'(rhs_q);
  assign sp_sh  = sp[2*VW-1:FRAC];
  assign upd    = spneg ? (ACC_W+1)'(xi) + (ACC_W+1)'(sp_sh)
                        : (ACC_W+1)'(xi) - (ACC_W+1)'(sp_sh);
  assign x_new  = sat_v(upd);
  assign conv   = norm < thr;
  assign last_sweep = conv || ((sweep_count + CNT_W'(1)) >= limit);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_data.req_type == REQ_SOLVE) state_next = ST_NRM;
        else if (in_acc && in_data.req_type == REQ_READ) state_next = ST_RD;
      end
      ST_RD:     if (out_free) state_next = ST_IDLE;
      ST_NRM:    if (j_idx == n_last) state_next = ST_NDRAIN;
      ST_NDRAIN: if (!nv1 && !nv2) state_next = ST_TH1;
      ST_TH1:    state_next = ST_TH2;
      ST_TH2:    state_next = th_pass ? ST_MAC : ST_TH1;
      ST_MAC:    if (j_idx == n_last) state_next = ST_DRAIN;
      ST_DRAIN:  if (!mac_busy) state_next = ST_FIN1;
      ST_FIN1:   state_next = ST_FIN2;
      ST_FIN2:   state_next = ST_FIN3;
      ST_FIN3:   state_next = (i_idx == n_last) ? ST_SWEND : ST_MAC;
      ST_SWEND:  state_next = last_sweep ? ST_DONE : ST_MAC;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      bank        <= 1'b0;
      xz          <= 1'b1;
      xv          <= 1'b0;
      nv1         <= 1'b0;
      nv2         <= 1'b0;
      sweep_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      nv1   <= (state == ST_NRM);
      nv2   <= nv1;
      if ((state == ST_RD || state == ST_DONE) && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == ST_TH2 && th_pass) begin
        sweep_count <= '0;
        xz          <= 1'b1;
      end
      if (state == ST_SWEND) begin
        sweep_count <= sweep_count + CNT_W'(1);
        bank        <= ~bank;
        xz          <= 1'b0;
        xv          <= 1'b1;
      end
    end
  end

  // Payload and counters.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rd_row <= in_data.row;
        j_idx  <= '0;
        i_idx  <= '0;
        rnorm  <= '0;
        th_pass <= 1'b0;
        if (order_in_use == '0) n_last <= '0;
        else if (order_in_use > ORD_W'(MAX_ORDER)) n_last <= IDX_W'(MAX_ORDER - 1);
        else n_last <= IDX_W'(order_in_use - ORD_W'(1));
        limit <= (iter_limit == '0) ? CNT_W'(1) : iter_limit;
      end
      ST_NRM: j_idx <= j_idx + IDX_W'(1);
      ST_NDRAIN: t_reg <= rnorm;
      ST_TH1: begin
        p_hi <= t_reg[NORM_W-1:FRAC] * tolerance;
        p_lo <= t_reg[FRAC-1:0] * tolerance;
      end
      ST_TH2: begin
        t_reg   <= th_sum;
        thr     <= th_sum;
        th_pass <= 1'b1;
        i_idx   <= '0;
        j_idx   <= '0;
        norm    <= '0;
      end
      ST_MAC: j_idx <= j_idx + IDX_W'(1);
      ST_FIN1: r_q <= sat_v(diff);
      ST_FIN2: begin
        sq    <= mag_v(r_q) * mag_v(r_q);
        sp    <= mag_v(step_size) * mag_v(r_q);
        spneg <= step_size[VW-1] ^ r_q[VW-1];
        xi    <= xz ? '0 : x_q;
      end
      ST_FIN3: begin
        norm  <= norm + NORM_W'(sq[2*VW-1:FRAC]);
        i_idx <= i_idx + IDX_W'(1);
        j_idx <= '0;
      end
      ST_SWEND: begin
        solved_last <= n_last;
        if (!last_sweep) begin
          norm  <= '0;
          i_idx <= '0;
          j_idx <= '0;
        end
      end
      default: ;
    endcase
    // Right-hand-side squares stream in two stages behind the reads.
    if (nv1) nsq <= mag_v(rhs_q) * mag_v(rhs_q);
    if (nv2) rnorm <= rnorm + NORM_W'(nsq[2*VW-1:FRAC]);
    if (state == ST_RD && out_free) begin
      out_data.is_status       <= 1'b0;
      out_data.solution_value  <= (xv && rd_row <= solved_last) ? x_q : '0;
      out_data.iterations_done <= '0;
      out_data.converged       <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_data.is_status       <= 1'b1;
      out_data.solution_value  <= '0;
      out_data.iterations_done <= sweep_count;
      out_data.converged       <= conv;
    end
  end

  // The pipeline has drained before a row's residual is formed.
  assert property (@(posedge clk) disable iff (rst) (state == ST_FIN1) |-> !mac_busy)
    else $error("row finish started with products in flight");

  // A finished solve has run at least one sweep and no more than its limit.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (sweep_count != '0 && sweep_count <= limit))
    else $error("sweep count outside limit at solve end");

  // Product issue leaves only toward the drain state.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |=> (state == ST_MAC || state == ST_DRAIN))
    else $error("unexpected exit from product issue");

endmodule
`default_nettype wire
